// ----- design/hpt_pkg.sv -----
// ----------------------------------------------------------------------------
// hpt_pkg
// Beat types and register indexes for the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

	// input beat: one point, signed fixed point
	typedef struct packed {
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} hpt_in_t;

	// output beat: transformed point and status flags
	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               did_divide;
		logic               saturated;
	} hpt_out_t;

	localparam int CFG_IDX_W = 4;

	// matrix register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

endpackage

// ----- design/homogeneous_point_transform.sv -----
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 matrix times (x, y, z, 1) with a pipelined perspective divide.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one point per beat.
//   out channel (out_valid/out_ready/out_data) returns one result per point,
//   in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the eight
//   64-bit matrix registers; cfg_ready is always high, indexes 8 and up are
//   ignored. Write them only while no point is in flight.
// Pipeline: input register, multiply, sum, divide setup, one restoring
// divide stage per quotient bit (COORD_WIDTH + 1 of them), output register.
// Throughput is one point per cycle while the receiver keeps up; the three
// divide lanes are fully pipelined so the divider sets no limit.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// in_ready drops in that same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  hpt_pkg::hpt_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output hpt_pkg::hpt_out_t              out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                    cfg_data
);
	import hpt_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int PW = 32 + CW;          // one product
	localparam int SW = PW + 2;           // sum of four terms
	localparam int VW = SW - FRAC_BITS;   // floored row result
	localparam int QW = CW + 1;           // quotient bits kept

	localparam logic signed [VW-1:0] VMAX = (VW'(1) <<< (CW - 1)) - VW'(1);
	localparam logic signed [VW-1:0] VMIN = -VMAX - VW'(1);
	localparam logic [QW-1:0] QPOS = (QW'(1) << (CW - 1)) - QW'(1);
	localparam logic [QW-1:0] QNEG = QW'(1) << (CW - 1);
	localparam logic signed [CW-1:0] CMAX = VMAX[CW-1:0];
	localparam logic signed [CW-1:0] CMIN = VMIN[CW-1:0];
	localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

	typedef struct packed {
		logic [VW-1:0]        rem;
		logic [QW-1:0]        q;
		logic [VW-1:0]        d;
		logic [SW-1:0]        n;
		logic                 neg;
		logic                 big;
		logic signed [VW-1:0] v;
	} lane_t;

	typedef struct packed {
		logic            vld;
		logic            dv;
		lane_t [2:0]     ln;
	} dstage_t;

	logic en;
	logic [63:0] cfg_q [8];
	logic signed [31:0] m [4][4];

	// global advance: output register empty or being drained
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) cfg_q[i] <= '0;
			cfg_q[0] <= ONE;
			cfg_q[2] <= ONE << 32;
			cfg_q[5] <= ONE;
			cfg_q[7] <= ONE << 32;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW0_COLS01: cfg_q[0] <= cfg_data;
				REG_ROW0_COLS23: cfg_q[1] <= cfg_data;
				REG_ROW1_COLS01: cfg_q[2] <= cfg_data;
				REG_ROW1_COLS23: cfg_q[3] <= cfg_data;
				REG_ROW2_COLS01: cfg_q[4] <= cfg_data;
				REG_ROW2_COLS23: cfg_q[5] <= cfg_data;
				REG_ROW3_COLS01: cfg_q[6] <= cfg_data;
				REG_ROW3_COLS23: cfg_q[7] <= cfg_data;
				default: ;
			endcase
		end
	end

	// matrix entries
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			m[r][0] = cfg_q[2*r][31:0];
			m[r][1] = cfg_q[2*r][63:32];
			m[r][2] = cfg_q[2*r+1][31:0];
			m[r][3] = cfg_q[2*r+1][63:32];
		end
	end

	// stage 1: input register
	logic vld_s1;
	logic signed [CW-1:0] c_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1[0] <= in_data.in_x[CW-1:0];
			c_s1[1] <= in_data.in_y[CW-1:0];
			c_s1[2] <= in_data.in_z[CW-1:0];
		end
	end

	// stage 2: twelve products
	logic vld_s2;
	logic signed [PW-1:0] prod_s2 [4][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 3; c++)
					prod_s2[r][c] <= PW'(m[r][c]) * PW'(c_s1[c]);
		end
	end

	// stage 3: row sums with translation, floored
	logic vld_s3;
	logic signed [VW-1:0] v_s3 [4];
	logic signed [SW-1:0] sum [4];

	always_comb begin
		for (int r = 0; r < 4; r++)
			sum[r] = SW'(prod_s2[r][0]) + SW'(prod_s2[r][1]) + SW'(prod_s2[r][2])
				+ (SW'(m[r][3]) <<< FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) v_s3[r] <= VW'(sum[r] >>> FRAC_BITS);
		end
	end

	// stage 4: divide setup (index 0), then one stage per quotient bit
	dstage_t div_s [QW+1];
	dstage_t prep;
	logic [VW-1:0] wabs;
	logic [VW-1:0] vabs;
	logic [SW-1:0] nhi;

	always_comb begin
		wabs = v_s3[3][VW-1] ? VW'(-v_s3[3]) : VW'(v_s3[3]);
		prep.vld = vld_s3;
		prep.dv  = (v_s3[3] != '0) && (v_s3[3] != (VW'(1) <<< FRAC_BITS));
		for (int l = 0; l < 3; l++) begin
			vabs = v_s3[l][VW-1] ? VW'(-v_s3[l]) : VW'(v_s3[l]);
			prep.ln[l].v   = v_s3[l];
			prep.ln[l].neg = v_s3[l][VW-1] ^ v_s3[3][VW-1];
			prep.ln[l].d   = wabs;
			prep.ln[l].n   = SW'(vabs) << FRAC_BITS;
			nhi            = prep.ln[l].n >> QW;
			prep.ln[l].big = nhi >= SW'(wabs);
			prep.ln[l].rem = nhi[VW-1:0];
			prep.ln[l].q   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_s[0] <= '0;
		else if (en) div_s[0] <= prep;
	end

	// restoring divide, quotient bit QW-k in stage k
	for (genvar k = 1; k <= QW; k++) begin : g_div
		dstage_t nxt;
		logic [VW:0] rem2;

		always_comb begin
			nxt = div_s[k-1];
			for (int l = 0; l < 3; l++) begin
				rem2 = {div_s[k-1].ln[l].rem, div_s[k-1].ln[l].n[QW-k]};
				if (rem2 >= {1'b0, div_s[k-1].ln[l].d}) begin
					rem2 = rem2 - {1'b0, div_s[k-1].ln[l].d};
					nxt.ln[l].q = {div_s[k-1].ln[l].q[QW-2:0], 1'b1};
				end else begin
					nxt.ln[l].q = {div_s[k-1].ln[l].q[QW-2:0], 1'b0};
				end
				nxt.ln[l].rem = rem2[VW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_s[k] <= '0;
			else if (en) div_s[k] <= nxt;
		end
	end

	// final select and saturation
	logic signed [CW-1:0] res [3];
	logic                 sat [3];
	lane_t                fl;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			fl     = div_s[QW].ln[l];
			sat[l] = 1'b0;
			if (div_s[QW].dv) begin
				if (fl.big) begin
					sat[l] = 1'b1;
					res[l] = fl.neg ? CMIN : CMAX;
				end else if (fl.neg) begin
					sat[l] = fl.q > QNEG;
					res[l] = sat[l] ? CMIN : CW'(-fl.q);
				end else begin
					sat[l] = fl.q > QPOS;
					res[l] = sat[l] ? CMAX : fl.q[CW-1:0];
				end
			end else if (fl.v > VMAX) begin
				sat[l] = 1'b1;
				res[l] = CMAX;
			end else if (fl.v < VMIN) begin
				sat[l] = 1'b1;
				res[l] = CMIN;
			end else begin
				res[l] = fl.v[CW-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= div_s[QW].vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.out_x      <= 32'(res[0]);
			out_data.out_y      <= 32'(res[1]);
			out_data.out_z      <= 32'(res[2]);
			out_data.did_divide <= div_s[QW].dv;
			out_data.saturated  <= sat[0] | sat[1] | sat[2];
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the homogeneous point transform: points are streamed through the
// input channel, the matrix is set up through the register channel between
// runs of points, and every result is compared field by field with a predicted transform
// (full-width row sums, floor to the fraction, perspective divide, clamp).
// ----------------------------------------------------------------------------
module tb_top;
	import hpt_pkg::*;

	localparam int FRAC = 16;
	localparam int PIPE_LAT = 38;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	hpt_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	hpt_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// matrix as the block should hold it, [row][col]
	logic signed [31:0] mat [4][4];
	hpt_out_t result_q [$];
	int err_count = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_hold = 0;

	homogeneous_point_transform dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// clamp to 32 bits, note any clamping
	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
			inout bit hit);
		if (v > 128'(S32_MAX)) begin
			hit = 1'b1;
			return S32_MAX;
		end
		if (v < 128'(S32_MIN)) begin
			hit = 1'b1;
			return S32_MIN;
		end
		return v[31:0];
	endfunction

	// transform one point with the current matrix
	function automatic hpt_out_t transform_point(input hpt_in_t p);
		logic signed [79:0] crd [3];
		logic signed [79:0] row_val [4];
		logic signed [79:0] ent;
		logic signed [79:0] acc;
		logic signed [127:0] num;
		logic signed [127:0] den;
		logic signed [127:0] quo;
		hpt_out_t r;
		bit hit;
		bit divide;
		crd[0] = p.in_x;
		crd[1] = p.in_y;
		crd[2] = p.in_z;
		hit = 1'b0;
		for (int i = 0; i < 4; i++) begin
			acc = '0;
			for (int j = 0; j < 3; j++) begin
				ent = mat[i][j];
				acc = acc + ent * crd[j];
			end
			ent = mat[i][3];
			acc = acc + (ent <<< FRAC);
			row_val[i] = acc >>> FRAC;
		end
		divide = (row_val[3] != 0) && (row_val[3] != 80'(ONE));
		den = row_val[3];
		for (int i = 0; i < 3; i++) begin
			num = row_val[i];
			quo = divide ? (num <<< FRAC) / den : num;
			case (i)
				0: r.out_x = clamp32(quo, hit);
				1: r.out_y = clamp32(quo, hit);
				default: r.out_z = clamp32(quo, hit);
			endcase
		end
		r.did_divide = divide;
		r.saturated = hit;
		return r;
	endfunction

	// one register write beat; caller lowers cfg_valid afterwards
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_ROW3_COLS23) begin
			mat[idx / 2][(idx % 2) * 2] = val[31:0];
			mat[idx / 2][(idx % 2) * 2 + 1] = val[63:32];
		end
	endtask

	// load a whole matrix, plus one write to an unused index
	task automatic load_matrix(input logic signed [31:0] m [4][4]);
		for (int i = int'(REG_ROW0_COLS01); i <= int'(REG_ROW3_COLS23); i++)
			write_reg(CFG_IDX_W'(i),
				{m[i / 2][(i % 2) * 2 + 1], m[i / 2][(i % 2) * 2]});
		write_reg(CFG_IDX_W'($urandom_range(int'(REG_ROW3_COLS23) + 1,
			2 ** CFG_IDX_W - 1)), {$urandom, $urandom});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// send one point beat, with a random gap in front of it
	task automatic send_point(input hpt_in_t p);
		if (tx_idle_on && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		result_q.push_back(transform_point(p));
	endtask

	// stop sending and wait for every result, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	function automatic hpt_in_t pt(input logic signed [31:0] x, y, z);
		hpt_in_t p;
		p.in_x = x;
		p.in_y = y;
		p.in_z = z;
		return p;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
			2: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
			default: return $urandom_range(1) ? S32_MAX : S32_MIN;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_entry();
		case ($urandom_range(5))
			0: return $urandom;
			1, 2: return $signed($urandom_range(0, 32'h0007_ffff)) - 32'sh0004_0000;
			3: return '0;
			4: return ONE;
			default: return $urandom_range(1) ? S32_MAX : S32_MIN;
		endcase
	endfunction

	task automatic rand_matrix(output logic signed [31:0] m [4][4]);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				m[i][j] = rand_entry();
		// mostly affine or perspective bottom rows, so w lands near one
		case ($urandom_range(3))
			0: m[3] = '{0, 0, 0, ONE};
			1: m[3] = '{0, 0, rand_entry(), 0};
			2: m[3] = '{0, 0, rand_entry(), rand_entry()};
			default: ;
		endcase
	endtask

	// receiver: stalls, long hold-off and result checks
	always @(posedge clk) begin
		hpt_out_t exp_r;
		if (out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				$error("result with no point outstanding: %p", out_data);
				err_count++;
			end else begin
				exp_r = result_q.pop_front();
				if (out_data.out_x !== exp_r.out_x) begin
					$error("out_x exp %h got %h", exp_r.out_x, out_data.out_x);
					err_count++;
				end
				if (out_data.out_y !== exp_r.out_y) begin
					$error("out_y exp %h got %h", exp_r.out_y, out_data.out_y);
					err_count++;
				end
				if (out_data.out_z !== exp_r.out_z) begin
					$error("out_z exp %h got %h", exp_r.out_z, out_data.out_z);
					err_count++;
				end
				if (out_data.did_divide !== exp_r.did_divide) begin
					$error("did_divide exp %b got %b", exp_r.did_divide,
						out_data.did_divide);
					err_count++;
				end
				if (out_data.saturated !== exp_r.saturated) begin
					$error("saturated exp %b got %b", exp_r.saturated,
						out_data.saturated);
					err_count++;
				end
			end
		end
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(rx_idle_on && $urandom_range(99) < 9);
		end
	end

	// identity matrix out of reset: pass-through, w exactly one
	task automatic test_reset_identity();
		mat = '{'{ONE, 0, 0, 0}, '{0, ONE, 0, 0}, '{0, 0, ONE, 0}, '{0, 0, 0, ONE}};
		send_point(pt(0, 0, 0));
		send_point(pt(S32_MAX, S32_MIN, -1));
		send_point(pt(S32_MIN, S32_MAX, 1));
		send_point(pt(32'sh5555_5555, 32'shaaaa_aaaa, ONE));
		drain();
	endtask

	// special cases of w and the extremes of the matrix entries
	task automatic test_special_w();
		logic signed [31:0] m [4][4];
		// w zero
		m = '{'{ONE, 0, 0, 0}, '{0, ONE, 0, 0}, '{0, 0, ONE, 0}, '{0, 0, 0, 0}};
		load_matrix(m);
		send_point(pt(ONE, -ONE, S32_MAX));
		send_point(pt(S32_MIN, 3, 0));
		drain();
		// perspective: w = z, includes w exactly one, w zero and tiny w
		m[3] = '{0, 0, ONE, 0};
		load_matrix(m);
		send_point(pt(4 * ONE, -6 * ONE, 2 * ONE));
		send_point(pt(7 * ONE, 5 * ONE, ONE));
		send_point(pt(7 * ONE, 5 * ONE, 0));
		send_point(pt(S32_MAX, S32_MIN, 1));
		send_point(pt(-3 * ONE, ONE, -ONE / 2));
		send_point(pt(ONE, ONE, -1));
		drain();
		// w far outside 32 bits
		m[3] = '{S32_MAX, S32_MAX, S32_MAX, S32_MAX};
		load_matrix(m);
		send_point(pt(S32_MAX, S32_MAX, S32_MAX));
		send_point(pt(S32_MIN, S32_MIN, S32_MIN));
		send_point(pt(ONE, 0, 0));
		drain();
		// most negative entries everywhere
		foreach (m[i, j]) m[i][j] = S32_MIN;
		load_matrix(m);
		send_point(pt(S32_MIN, S32_MIN, S32_MIN));
		send_point(pt(S32_MAX, S32_MAX, S32_MAX));
		send_point(pt(-1, 0, 1));
		drain();
		// most positive entries, row 3 holds only a translation
		foreach (m[i, j]) m[i][j] = S32_MAX;
		m[3] = '{0, 0, 0, ONE + 1};
		load_matrix(m);
		send_point(pt(S32_MAX, S32_MIN, 0));
		send_point(pt(ONE, ONE, ONE));
		drain();
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		logic signed [31:0] m [4][4];
		rand_matrix(m);
		load_matrix(m);
		rx_hold = 200;
		for (int n = 0; n < 80; n++) send_point(pt(rand_coord(), rand_coord(), rand_coord()));
		drain();
	endtask

	// random matrices and points, one phase with no idling at all
	task automatic test_random();
		logic signed [31:0] m [4][4];
		for (int ph = 0; ph < 10; ph++) begin
			rand_matrix(m);
			load_matrix(m);
			tx_idle_on = (ph != 4);
			rx_idle_on = (ph != 4);
			for (int n = 0; n < 65; n++)
				send_point(pt(rand_coord(), rand_coord(), rand_coord()));
			drain();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_identity();
		test_special_w();
		test_backpressure();
		test_random();
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
